@@ hw/rtl/hob_pkg.sv @@
// shared constants, types and codes for the heap occupancy bitmap
package hob_pkg;

  localparam int HEAP_BYTES_MAX = 65536;
  localparam int WORD_BITS      = 64;
  localparam int NUM_WORDS      = (HEAP_BYTES_MAX + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W         = $clog2(NUM_WORDS);
  localparam int BIT_W          = $clog2(WORD_BITS);
  localparam int POS_W          = ADDR_W + BIT_W;
  localparam int POP_W          = BIT_W + 1;

  // field widths fixed by the channel formats
  localparam int CMD_W   = 2;
  localparam int START_W = 16;
  localparam int LEN_W   = 17;
  localparam int CNT_W   = 17;
  localparam int DIST_W  = 16;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] HEAP_MAX_C = CFG_W'(HEAP_BYTES_MAX);
  localparam logic [CFG_W-1:0] CFG_RESET_C = CFG_W'(65536);

  typedef enum logic [CMD_W-1:0] {
    CMD_MARK  = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_COUNT = 2'd2,
    CMD_FIND  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_BYTES = 1'b0,
    CFG_SEARCH_END = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  // request towards the bitmap store
  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 re;
    logic [ADDR_W-1:0]    raddr;
  } ram_req_t;

  // per-word summary from the word unit
  typedef struct packed {
    logic [POP_W-1:0] pop;
    logic             hit;
    logic [BIT_W-1:0] hit_idx;
  } word_res_t;

endpackage

@@ hw/rtl/hob_if.sv @@
// valid/ready channel interfaces for commands and results
interface hob_in_if import hob_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [START_W-1:0] start_req;
  logic [LEN_W-1:0]   length;

  modport source (output valid, command, start_req, length, input ready);
  modport sink   (input valid, command, start_req, length, output ready);
endinterface

interface hob_out_if import hob_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [CNT_W-1:0]  used_count;
  logic              found;
  logic [DIST_W-1:0] distance;

  modport source (output valid, status, used_count, found, distance, input ready);
  modport sink   (input valid, status, used_count, found, distance, output ready);
endinterface

@@ hw/rtl/hob_ram.sv @@
// generic simple dual-port ram with registered read
module hob_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/hob_word.sv @@
// per-word range mask, update, population count and first-used search
module hob_word import hob_pkg::*; (
  input  logic [WORD_BITS-1:0] data,
  input  logic [BIT_W-1:0]     lb,
  input  logic [BIT_W-1:0]     ub,
  input  logic                 set_bits,
  output logic [WORD_BITS-1:0] new_word,
  output word_res_t            res
);

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] sel;

  // bits lb..ub inclusive
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (BIT_W'(i) >= lb) && (BIT_W'(i) <= ub);
    end
  end

  assign sel      = data & mask;
  assign new_word = set_bits ? (data | mask) : (data & ~mask);

  // count and lowest used bit inside the range
  always_comb begin
    res.pop     = POP_W'($countones(sel));
    res.hit     = |sel;
    res.hit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (sel[i]) begin
        res.hit_idx = BIT_W'(i);
      end
    end
  end

endmodule

@@ hw/rtl/hob_seq.sv @@
// command sequencer: range check, word walk over the store, result register
module hob_seq import hob_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  hob_in_if.sink               in_ch,
  hob_out_if.source            out_ch,
  output ram_req_t             ram_req,
  input  logic [WORD_BITS-1:0] ram_rdata
);

  state_t               state_r, state_nxt;
  logic [ADDR_W-1:0]    clr_addr_r, clr_addr_nxt;
  logic [CFG_W-1:0]     heap_cfg_r, heap_cfg_nxt;
  logic [CFG_W-1:0]     send_cfg_r, send_cfg_nxt;
  logic                 p_vld_r, p_vld_nxt;
  logic                 ov_r, ov_nxt;

  cmd_t                 cmd_r, cmd_nxt;
  logic [START_W-1:0]   start_r, start_nxt;
  logic [START_W-1:0]   last_r, last_nxt;
  logic [ADDR_W-1:0]    rd_addr_r, rd_addr_nxt;
  logic [ADDR_W-1:0]    p_addr_r, p_addr_nxt;
  logic                 st_r, st_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 fnd_r, fnd_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;

  logic                 o_status_r;
  logic [CNT_W-1:0]     o_count_r;
  logic                 o_found_r;
  logic [DIST_W-1:0]    o_dist_r;
  logic                 out_load;

  logic [CFG_W-1:0]     heap;
  logic [CFG_W-1:0]     lim;
  logic [CFG_W:0]       end_sum;
  logic                 acc_rej;
  logic                 acc_empty;
  logic [START_W-1:0]   acc_last;
  cmd_t                 in_cmd;

  logic [BIT_W-1:0]     lb, ub;
  logic [WORD_BITS-1:0] new_word;
  word_res_t            wres;

  // configuration registers
  always_comb begin
    heap_cfg_nxt = heap_cfg_r;
    send_cfg_nxt = send_cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HEAP_BYTES: heap_cfg_nxt = cfg_wdata;
        CFG_SEARCH_END: send_cfg_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // range check of the incoming command
  assign in_cmd  = cmd_t'(in_ch.command);
  assign heap    = (heap_cfg_r > HEAP_MAX_C) ? HEAP_MAX_C : heap_cfg_r;
  assign lim     = (send_cfg_r < heap) ? send_cfg_r : heap;
  assign end_sum = {2'b00, in_ch.start_req} + {1'b0, in_ch.length};

  always_comb begin
    if (in_cmd == CMD_FIND) begin
      acc_rej   = {1'b0, in_ch.start_req} >= heap;
      acc_empty = lim <= {1'b0, in_ch.start_req};
      acc_last  = START_W'(lim - CFG_W'(1));
    end else begin
      acc_rej   = end_sum > {1'b0, heap};
      acc_empty = in_ch.length == '0;
      acc_last  = START_W'(end_sum - (CFG_W + 1)'(1));
    end
  end

  // bit bounds for the word coming back from the store
  assign lb = (p_addr_r == start_r[POS_W-1:BIT_W]) ? start_r[BIT_W-1:0] : '0;
  assign ub = (p_addr_r == last_r[POS_W-1:BIT_W])  ? last_r[BIT_W-1:0]  : '1;

  hob_word u_word (
    .data     (ram_rdata),
    .lb       (lb),
    .ub       (ub),
    .set_bits (cmd_r == CMD_MARK),
    .new_word (new_word),
    .res      (wres)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_load    = (state_r == ST_FIN) && (!ov_r || out_ch.ready);

  // next state and store access
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    cmd_nxt      = cmd_r;
    start_nxt    = start_r;
    last_nxt     = last_r;
    rd_addr_nxt  = rd_addr_r;
    p_vld_nxt    = 1'b0;
    p_addr_nxt   = rd_addr_r;
    st_nxt       = st_r;
    cnt_nxt      = cnt_r;
    fnd_nxt      = fnd_r;
    pos_nxt      = pos_r;
    ram_req      = '0;

    // second half of the walk: modify and write back, or accumulate
    if (p_vld_r) begin
      case (cmd_r)
        CMD_MARK, CMD_FREE: begin
          ram_req.we    = 1'b1;
          ram_req.waddr = p_addr_r;
          ram_req.wdata = new_word;
        end
        CMD_COUNT: cnt_nxt = cnt_r + CNT_W'(wres.pop);
        CMD_FIND: begin
          if (wres.hit && !fnd_r) begin
            fnd_nxt = 1'b1;
            pos_nxt = {p_addr_r, wres.hit_idx};
          end
        end
        default: ;
      endcase
    end

    case (state_r)
      ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr_r;
        ram_req.wdata = '0;
        clr_addr_nxt  = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(NUM_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt     = in_cmd;
          start_nxt   = in_ch.start_req;
          last_nxt    = acc_last;
          rd_addr_nxt = in_ch.start_req[POS_W-1:BIT_W];
          st_nxt      = acc_rej;
          cnt_nxt     = '0;
          fnd_nxt     = 1'b0;
          if (acc_rej || acc_empty) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = rd_addr_r;
        if (cmd_r == CMD_FIND && p_vld_r && wres.hit) begin
          state_nxt = ST_FIN;
        end else begin
          p_vld_nxt = 1'b1;
          if (rd_addr_r == last_r[POS_W-1:BIT_W]) begin
            state_nxt = ST_DRAIN;
          end else begin
            rd_addr_nxt = rd_addr_r + ADDR_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    ov_nxt = ov_r;
    if (out_load) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      heap_cfg_r <= CFG_RESET_C;
      send_cfg_r <= CFG_RESET_C;
      p_vld_r    <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      heap_cfg_r <= heap_cfg_nxt;
      send_cfg_r <= send_cfg_nxt;
      p_vld_r    <= p_vld_nxt;
      ov_r       <= ov_nxt;
    end
  end

  // command and accumulator registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    start_r   <= start_nxt;
    last_r    <= last_nxt;
    rd_addr_r <= rd_addr_nxt;
    p_addr_r  <= p_addr_nxt;
    st_r      <= st_nxt;
    cnt_r     <= cnt_nxt;
    fnd_r     <= fnd_nxt;
    pos_r     <= pos_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_status_r <= st_r;
      o_count_r  <= cnt_r;
      o_found_r  <= fnd_r;
      o_dist_r   <= fnd_r ? DIST_W'(START_W'(pos_r) - start_r) : '0;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.status     = o_status_r;
  assign out_ch.used_count = o_count_r;
  assign out_ch.found      = o_found_r;
  assign out_ch.distance   = o_dist_r;

  // the store is only written while clearing or walking a mark or free
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_FIN) |-> !ram_req.we)
    else $error("store written outside a walk");

  // the walk never reads past the last word of the range
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> rd_addr_r <= last_r[POS_W-1:BIT_W])
    else $error("walk beyond last word");

  // a finished result waits while the output register is still taken
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && ov_r && !out_ch.ready) |=> state_r == ST_FIN)
    else $error("result overwrote a pending transfer");

  // a hit can only come from a find walk
  a_found_find: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && fnd_r) |-> cmd_r == CMD_FIND)
    else $error("found set by a non-find command");

endmodule

@@ hw/rtl/heap_occupancy_bitmap_top.sv @@
// top level of the heap occupancy bitmap: sequencer and bitmap store
//
//  channel   dir  handshake        payload
//  in_chan   in   valid/ready      command, start_req, length
//  out_chan  out  valid/ready      status, used_count, found, distance
//  cfg_*     in   cfg_we           cfg_index, cfg_wdata (heap_bytes, search_end)
//
// a command is accepted, walks the 64-bit bitmap words of its range (a find stops
// at a hit), drains the store read, then loads the result; rejected and empty ones
// skip the walk. the walk is paced by the single read port and write port of the store.
// after reset a clearing pass writes all 1024 words with in_chan not ready.
// a result waiting in the output register stalls only the final step of the next command.
module heap_occupancy_bitmap_top import hob_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  hob_in_if.sink               in_chan,
  hob_out_if.source            out_chan
);

  ram_req_t             ram_req;
  logic [WORD_BITS-1:0] ram_rdata;

  // command sequencer
  hob_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_chan),
    .out_ch    (out_chan),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // bitmap store, one bit per heap byte
  hob_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for the heap occupancy bitmap: directed, config, backpressure, random
module testbench;
  import hob_pkg::*;

  typedef struct packed {
    logic              status;
    logic [CNT_W-1:0]  used_count;
    logic              found;
    logic [DIST_W-1:0] distance;
  } occ_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  hob_in_if  cmd_if ();
  hob_out_if res_if ();

  heap_occupancy_bitmap_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (cmd_if),
    .out_chan  (res_if)
  );

  // shadow of the bitmap and the two registers
  bit               used_map [HEAP_BYTES_MAX];
  logic [CFG_W-1:0] heap_bytes_reg = CFG_RESET_C;
  logic [CFG_W-1:0] search_end_reg = CFG_RESET_C;

  occ_result_t pending_results[$];

  int error_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int reject_tally = 0;
  int found_tally = 0;
  int phase_tally = 0;
  int cmd_tally [4] = '{0, 0, 0, 0};

  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  int ready_hold_cycles = 0;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned heap_in_force();
    return (heap_bytes_reg > HEAP_MAX_C) ? HEAP_BYTES_MAX : int'(heap_bytes_reg);
  endfunction

  // work out the result of one command and apply it to the shadow bitmap
  function automatic occ_result_t predict_command(cmd_t cmd, logic [START_W-1:0] start,
                                                  logic [LEN_W-1:0] len);
    occ_result_t r;
    int unsigned heap, lim, s, n, cnt, i;
    r = '0;
    heap = heap_in_force();
    s = start;
    n = len;
    if (cmd == CMD_FIND) begin
      if (s >= heap) begin
        r.status = 1'b1;
      end else begin
        lim = (search_end_reg < heap) ? int'(search_end_reg) : heap;
        for (i = s; i < lim && !r.found; i++) begin
          if (used_map[i]) begin
            r.found = 1'b1;
            r.distance = DIST_W'(i - s);
          end
        end
      end
    end else if (s + n > heap) begin
      r.status = 1'b1;
    end else if (cmd == CMD_COUNT) begin
      cnt = 0;
      for (i = 0; i < n; i++) cnt += used_map[s + i];
      r.used_count = CNT_W'(cnt);
    end else begin
      for (i = 0; i < n; i++) used_map[s + i] = (cmd == CMD_MARK);
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  // offer one command, called at a rising edge; returns at the edge of its transfer
  task automatic send_command(cmd_t cmd, logic [START_W-1:0] start, logic [LEN_W-1:0] len);
    int gap;
    occ_result_t r;
    gap = sender_idles ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.command   <= cmd;
    cmd_if.start_req <= start;
    cmd_if.length    <= len;
    do @(posedge clk); while (!cmd_if.ready);
    r = predict_command(cmd, start, len);
    pending_results = {pending_results, r};
    items_sent++;
    cmd_tally[cmd]++;
    reject_tally += r.status;
    found_tally += r.found;
  endtask

  // lower valid and wait until every expected result is back
  task automatic wait_until_drained();
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write both registers on consecutive edges while the block is idle
  task automatic set_limits(logic [CFG_W-1:0] heap, logic [CFG_W-1:0] limit);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HEAP_BYTES;
    cfg_wdata <= heap;
    @(posedge clk);
    cfg_index <= CFG_SEARCH_END;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    heap_bytes_reg = heap;
    search_end_reg = limit;
    phase_tally++;
  endtask

  // mostly legal ranges inside the heap, some overruns and some raw noise
  task automatic send_random_command();
    int unsigned heap, s, n, room, pick;
    cmd_t cmd;
    heap = heap_in_force();
    cmd = cmd_t'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 6 || heap == 0) begin
      s = $urandom_range(0, 65535);
      n = $urandom_range(0, 131071);
    end else if (pick < 14) begin
      s = $urandom_range(0, (heap > 65535) ? 65535 : heap);
      n = heap - s + $urandom_range(1, 64);
    end else begin
      s = $urandom_range(0, heap - 1);
      room = heap - s;
      n = $urandom_range(0, (pick < 90 && room > 200) ? 200 : room);
    end
    send_command(cmd, START_W'(s), LEN_W'(n));
  endtask

  // default limits: empty map, boundaries of the heap, full-range ops
  task automatic test_reset_state_and_extremes();
    send_command(CMD_FIND,  16'd0,     17'd0);
    send_command(CMD_MARK,  16'd100,   17'd37);
    send_command(CMD_COUNT, 16'd90,    17'd60);
    send_command(CMD_FIND,  16'd0,     17'h1FFFF);
    send_command(CMD_FREE,  16'd110,   17'd5);
    send_command(CMD_COUNT, 16'd100,   17'd37);
    send_command(CMD_MARK,  16'hFFFF,  17'd0);
    send_command(CMD_MARK,  16'hFFFF,  17'd2);
    send_command(CMD_COUNT, 16'd0,     17'h1FFFF);
    send_command(CMD_FREE,  16'd0,     17'd65536);
    send_command(CMD_MARK,  16'hFFFF,  17'd1);
    send_command(CMD_FIND,  16'd0,     17'd0);
    send_command(CMD_MARK,  16'd0,     17'd65536);
    send_command(CMD_COUNT, 16'd0,     17'd65536);
    send_command(CMD_FREE,  16'd0,     17'd65536);
    wait_until_drained();
  endtask

  // zero, oversized and one-byte heaps; search limits below and above the start
  task automatic test_config_extremes();
    set_limits(17'd0, 17'h1FFFF);
    send_command(CMD_MARK,  16'd0,    17'd0);
    send_command(CMD_COUNT, 16'd0,    17'd1);
    send_command(CMD_FIND,  16'd0,    17'd0);
    wait_until_drained();
    set_limits(17'h1FFFF, 17'd0);
    send_command(CMD_MARK,  16'hFFF0, 17'd16);
    send_command(CMD_FIND,  16'hFFF0, 17'd0);
    wait_until_drained();
    set_limits(17'd1, 17'd1);
    send_command(CMD_COUNT, 16'd0,    17'd1);
    send_command(CMD_MARK,  16'd0,    17'd1);
    send_command(CMD_FIND,  16'd0,    17'd0);
    send_command(CMD_COUNT, 16'd0,    17'd2);
    wait_until_drained();
    set_limits(17'd65536, 17'd200);
    send_command(CMD_FIND,  16'd150,  17'd0);
    wait_until_drained();
  endtask

  // long output stall with the sender pushing back to back, then a full pause
  task automatic test_output_backpressure();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    set_limits(17'd4096, 17'd4096);
    ready_hold_cycles = 400;
    repeat (14) send_random_command();
    wait_until_drained();
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // random phases over a spread of heap sizes and search limits
  task automatic test_random_traffic();
    logic [CFG_W-1:0] phase_heap [8];
    int unsigned lim_heap;
    logic [CFG_W-1:0] limit;
    phase_heap = '{17'd4096, 17'd65536, 17'd512, 17'h1FFFF, 17'd64, 17'd2048, 17'd1, 17'd30000};
    for (int p = 0; p < 8; p++) begin
      lim_heap = (phase_heap[p] > HEAP_MAX_C) ? HEAP_BYTES_MAX : int'(phase_heap[p]);
      limit = ($urandom_range(0, 4) == 0) ? 17'h1FFFF
                                          : CFG_W'($urandom_range(0, lim_heap + 100));
      set_limits(phase_heap[p], limit);
      sender_idles = (p % 3 != 1);
      receiver_idles = (p % 4 != 2);
      repeat (238) send_random_command();
      wait_until_drained();
    end
  endtask

  // result side: stalls, transfers and the field-by-field comparison
  initial begin : result_checker
    int stall;
    occ_result_t want;
    res_if.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (ready_hold_cycles > 0) begin
        stall = ready_hold_cycles;
        ready_hold_cycles = 0;
      end else begin
        stall = receiver_idles ? $urandom_range(0, 13) : 0;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: status %0d count %0d found %0d dist %0d",
               res_if.status, res_if.used_count, res_if.found, res_if.distance);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status",     want.status,     res_if.status);
        check_field("used_count", want.used_count, res_if.used_count);
        check_field("found",      want.found,      res_if.found);
        check_field("distance",   want.distance,   res_if.distance);
      end
    end
  end

  // run limit
  initial begin : run_limit
    #150000000;
    $display("simulation failed");
    $finish;
  end

  // main sequence
  initial begin : main_sequence
    cmd_if.valid     = 1'b0;
    cmd_if.command   = CMD_MARK;
    cmd_if.start_req = '0;
    cmd_if.length    = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state_and_extremes();
    test_config_extremes();
    test_output_backpressure();
    test_random_traffic();

    wait_until_drained();
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end

    $display("run covered %0d commands (mark %0d, free %0d, count %0d, find %0d), %0d results",
             items_sent, cmd_tally[CMD_MARK], cmd_tally[CMD_FREE], cmd_tally[CMD_COUNT],
             cmd_tally[CMD_FIND], results_seen);
    $display("%0d rejected ranges, %0d finds that hit a used byte, %0d register settings",
             reject_tally, found_tally, phase_tally);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/hob_pkg.sv
hw/rtl/hob_if.sv
hw/rtl/hob_ram.sv
hw/rtl/hob_word.sv
hw/rtl/hob_seq.sv
hw/rtl/heap_occupancy_bitmap_top.sv
dv/testbench.sv
